### rtl/rlbs_pkg.sv
// ----------------------------------------------------------------------------
// rlbs_pkg
// Shared types and constants for the RTP loss and burst statistics block.
// ----------------------------------------------------------------------------
package rlbs_pkg;

    // Operation codes carried in the input tuser field
    localparam logic [1:0] OP_RECV    = 2'd0;
    localparam logic [1:0] OP_DISCARD = 2'd1;
    localparam logic [1:0] OP_REPORT  = 2'd2;

    // Width of the shared compare-and-subtract unit. It holds x*512 + T for
    // x up to 2^32-1 and T up to 3*2^32, and the divisor 2T shifted by 8.
    localparam int unsigned DIV_W = 44;

    // Result field widths
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned SLOT_W = 17;
    localparam int unsigned FRAC_W = 9;
    localparam int unsigned TOT_W  = 34;

    // Register map
    localparam logic REG_GAP_MIN = 1'b0;
    localparam logic [7:0] GAP_MIN_RESET = 8'd16;

    // Control of the seen-bitmap store
    typedef struct packed {
        logic wr_en;
        logic wr_bit;
        logic rd_en;
    } t_ram_ctl;

endpackage

### rtl/rlbs_cmpsub.sv
// ----------------------------------------------------------------------------
// rlbs_cmpsub
// Shared compare-and-subtract unit used for sequence reduction and division.
// ----------------------------------------------------------------------------
module rlbs_cmpsub (
    input  logic [rlbs_pkg::DIV_W-1:0] i_a,
    input  logic [rlbs_pkg::DIV_W-1:0] i_b,
    output logic                       o_ge,
    output logic [rlbs_pkg::DIV_W-1:0] o_diff
);

    logic [rlbs_pkg::DIV_W:0] w_sub;

    // The borrow out of the widened subtraction tells whether a is below b.
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[rlbs_pkg::DIV_W];
    assign o_diff = w_sub[rlbs_pkg::DIV_W-1:0];

endmodule

### rtl/rlbs_seen_ram.sv
// ----------------------------------------------------------------------------
// rlbs_seen_ram
// One-bit-wide seen-bitmap store with one write port and a registered read.
// ----------------------------------------------------------------------------
module rlbs_seen_ram #(
    parameter int unsigned DEPTH = 65536,
    parameter int unsigned AW    = 16
) (
    input  logic              i_clk,
    input  rlbs_pkg::t_ram_ctl i_ctl,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [AW-1:0]     i_rd_addr,
    output logic              o_rd_bit
);

    logic r_mem [DEPTH];
    logic r_rd_bit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_ctl.wr_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_bit <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_bit = r_rd_bit;

endmodule

### rtl/rtp_loss_burst_statistics.sv
// Discard beats, and receive beats with a power-of-two store depth, finish in the
// idle state; other receive beats wait in S_MOD while the shared unit reduces the
// sequence number. A report beat walks the bitmap, forms the total, then computes
// the three fractions on the shared compare-and-subtract unit and waits for a free
// output register; one item is in work at a time.
// After reset a clearing pass writes every slot.
// ----------------------------------------------------------------------------
// rtp_loss_burst_statistics
// Receiver loss statistics: seen-bitmap, saturating counters, burst measure
// and rounded fractions computed on one shared subtract unit.
// ----------------------------------------------------------------------------
module rtp_loss_burst_statistics #(
    parameter int unsigned SEQ_STORE_DEPTH = 65536
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [15:0]  i_s_tdata,   // [15:0] seq_no
    input  logic [1:0]   i_s_tuser,   // [1:0] op
    // Result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] received_count, [63:32] discarded_count, [80:64] lost_count,
    // [89:81] fraction_lost, [98:90] fraction_discarded,
    // [115:99] burst_count, [124:116] burst_ratio, [127:125] zero
    output logic [127:0] o_m_tdata
);

    localparam int unsigned AW        = $clog2(SEQ_STORE_DEPTH);
    localparam int unsigned FW        = $clog2(SEQ_STORE_DEPTH + 1);
    localparam bit          POW2      = (SEQ_STORE_DEPTH & (SEQ_STORE_DEPTH - 1)) == 0;
    localparam int unsigned MOD_SHIFT = $clog2(65536 / SEQ_STORE_DEPTH);
    localparam int unsigned DW        = rlbs_pkg::DIV_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_WALK  = 4'd3;
    localparam logic [3:0] S_TAIL  = 4'd4;
    localparam logic [3:0] S_TOTAL = 4'd5;
    localparam logic [3:0] S_DSET  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    localparam logic [1:0] SEL_LOST  = 2'd0;
    localparam logic [1:0] SEL_DISC  = 2'd1;
    localparam logic [1:0] SEL_BURST = 2'd2;

    logic [3:0]     r_state, n_state;
    logic [AW-1:0]  r_clr, n_clr;
    logic [7:0]     r_gap_min;
    logic [FW-1:0]  r_fill, n_fill;
    logic [31:0]    r_recv, n_recv;
    logic [31:0]    r_disc, n_disc;
    logic [FW-1:0]  r_issue, n_issue;
    logic           r_rd_pend, n_rd_pend;
    logic [FW-1:0]  r_lost, n_lost;
    logic [FW-1:0]  r_run, n_run;
    logic [8:0]     r_gap, n_gap;
    logic           r_open, n_open;
    logic [FW-1:0]  r_bursts, n_bursts;
    logic [rlbs_pkg::TOT_W-1:0] r_total, n_total;
    logic [DW-1:0]  r_rem, n_rem;
    logic [DW-1:0]  r_den_sh, n_den_sh;
    logic [3:0]     r_k, n_k;
    logic [1:0]     r_sel, n_sel;
    logic [8:0]     r_q, n_q;
    logic [8:0]     r_fl, n_fl;
    logic [8:0]     r_fd, n_fd;
    logic [8:0]     r_bd, n_bd;
    logic           r_out_valid, n_out_valid;
    logic [127:0]   r_out_data, n_out_data;

    rlbs_pkg::t_ram_ctl w_ram_ctl;
    logic [AW-1:0]  w_wr_addr;
    logic [AW-1:0]  w_rd_addr;
    logic           w_rd_bit;
    logic           w_ge;
    logic [DW-1:0]  w_diff;
    logic           w_in_acc;
    logic           w_cfg_wr;
    logic [8:0]     w_gap_inc;
    logic [31:0]    w_x;
    logic [8:0]     w_q_next;

    rlbs_seen_ram #(
        .DEPTH (SEQ_STORE_DEPTH),
        .AW    (AW)
    ) u_seen_ram (
        .i_clk     (i_clk),
        .i_ctl     (w_ram_ctl),
        .i_wr_addr (w_wr_addr),
        .i_rd_addr (w_rd_addr),
        .o_rd_bit  (w_rd_bit)
    );

    rlbs_cmpsub u_cmpsub (
        .i_a    (r_rem),
        .i_b    (r_den_sh),
        .o_ge   (w_ge),
        .o_diff (w_diff)
    );

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & (paddr[2] == rlbs_pkg::REG_GAP_MIN);
    assign prdata   = (paddr[2] == rlbs_pkg::REG_GAP_MIN) ? {24'd0, r_gap_min} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_min <= rlbs_pkg::GAP_MIN_RESET;
        end else if (w_cfg_wr) begin
            r_gap_min <= pwdata[7:0];
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_tvalid & o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign w_gap_inc = w_rd_bit ? (r_gap + 9'd1) : 9'd0;

    always_comb begin
        unique case (r_sel)
            SEL_LOST:  w_x = 32'(r_lost);
            SEL_DISC:  w_x = r_disc;
            SEL_BURST: w_x = 32'(r_bursts);
            default:   w_x = 32'd0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_fill      = r_fill;
        n_recv      = r_recv;
        n_disc      = r_disc;
        n_issue     = r_issue;
        n_rd_pend   = 1'b0;
        n_lost      = r_lost;
        n_run       = r_run;
        n_gap       = r_gap;
        n_open      = r_open;
        n_bursts    = r_bursts;
        n_total     = r_total;
        n_rem       = r_rem;
        n_den_sh    = r_den_sh;
        n_k         = r_k;
        n_sel       = r_sel;
        n_q         = r_q;
        n_fl        = r_fl;
        n_fd        = r_fd;
        n_bd        = r_bd;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_ram_ctl   = '0;
        w_wr_addr   = r_clr;
        w_rd_addr   = r_issue[AW-1:0];
        w_q_next    = r_q;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_ram_ctl.wr_en = 1'b1;
                if (r_clr == AW'(SEQ_STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
                n_clr = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_s_tuser)
                        rlbs_pkg::OP_RECV: begin
                            if (r_recv != 32'hFFFF_FFFF) begin
                                n_recv = r_recv + 32'd1;
                            end
                            if (r_fill != FW'(SEQ_STORE_DEPTH)) begin
                                n_fill = r_fill + 1'b1;
                            end
                            if (POW2) begin
                                w_ram_ctl.wr_en  = 1'b1;
                                w_ram_ctl.wr_bit = 1'b1;
                                w_wr_addr        = i_s_tdata[AW-1:0];
                            end else begin
                                n_rem    = DW'(i_s_tdata);
                                n_den_sh = DW'(SEQ_STORE_DEPTH) << MOD_SHIFT;
                                n_k      = 4'(MOD_SHIFT);
                                n_state  = S_MOD;
                            end
                        end
                        rlbs_pkg::OP_DISCARD: begin
                            if (r_disc != 32'hFFFF_FFFF) begin
                                n_disc = r_disc + 32'd1;
                            end
                        end
                        rlbs_pkg::OP_REPORT: begin
                            n_issue  = '0;
                            n_lost   = '0;
                            n_run    = '0;
                            n_gap    = '0;
                            n_open   = 1'b0;
                            n_bursts = '0;
                            n_state  = S_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOD: begin
                // Restoring reduction of the sequence number by the store depth
                if (w_ge) begin
                    n_rem = w_diff;
                end
                if (r_k == 4'd0) begin
                    w_ram_ctl.wr_en  = 1'b1;
                    w_ram_ctl.wr_bit = 1'b1;
                    w_wr_addr        = w_ge ? w_diff[AW-1:0] : r_rem[AW-1:0];
                    n_state          = S_IDLE;
                end else begin
                    n_k      = r_k - 4'd1;
                    n_den_sh = r_den_sh >> 1;
                end
            end
            S_WALK: begin
                if (r_issue < r_fill) begin
                    w_ram_ctl.rd_en = 1'b1;
                    n_issue         = r_issue + 1'b1;
                    n_rd_pend       = 1'b1;
                end else if (!r_rd_pend) begin
                    n_state = S_TAIL;
                end
                // The read data of the slot issued last cycle is valid now.
                if (r_rd_pend) begin
                    if (!w_rd_bit) begin
                        n_lost = r_lost + 1'b1;
                    end
                    if (r_open) begin
                        if (w_gap_inc >= {1'b0, r_gap_min}) begin
                            n_bursts = r_bursts + (r_run - FW'(r_gap_min));
                            n_open   = 1'b0;
                            n_run    = '0;
                            n_gap    = '0;
                        end else begin
                            n_gap = w_gap_inc;
                            n_run = r_run + 1'b1;
                        end
                    end else if (!w_rd_bit) begin
                        n_open = 1'b1;
                        n_run  = r_run + 1'b1;
                    end
                end
            end
            S_TAIL: begin
                // A burst still open at the end counts if it outgrew the gap.
                if (r_run > FW'(r_gap_min)) begin
                    n_bursts = r_bursts + (r_run - FW'(r_gap_min));
                end
                n_state = S_TOTAL;
            end
            S_TOTAL: begin
                n_total = rlbs_pkg::TOT_W'(r_recv) + rlbs_pkg::TOT_W'(r_disc)
                        + rlbs_pkg::TOT_W'(r_lost);
                n_sel   = SEL_LOST;
                n_state = S_DSET;
            end
            S_DSET: begin
                // Quotient of (x*512 + T) / 2T, found bit by bit from bit 8 down.
                n_q      = '0;
                n_rem    = (DW'(w_x) << 9) + DW'(r_total);
                n_den_sh = DW'(r_total) << 9;
                n_k      = 4'd8;
                if (r_total == '0) begin
                    n_state = S_OUT;
                    w_q_next = 9'd0;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_k == 4'd8) begin
                    if (w_ge) begin
                        w_q_next = 9'd256;
                        n_state  = S_OUT;
                    end else begin
                        n_k      = 4'd7;
                        n_den_sh = r_den_sh >> 1;
                    end
                end else begin
                    if (w_ge) begin
                        n_rem    = w_diff;
                        w_q_next = r_q | (9'd1 << r_k[2:0]);
                    end
                    n_q = w_q_next;
                    if (r_k == 4'd0) begin
                        n_state = S_OUT;
                    end else begin
                        n_k      = r_k - 4'd1;
                        n_den_sh = r_den_sh >> 1;
                    end
                end
            end
            S_OUT: begin
                // Next fraction, or the result beat once the output register frees.
                if (r_sel != SEL_BURST) begin
                    n_sel   = r_sel + 2'd1;
                    n_state = S_DSET;
                end else if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {3'd0, r_q, 17'(r_bursts), r_fd, r_fl,
                                   17'(r_lost), r_disc, r_recv};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The finished quotient enters its slot; the third one stays in r_q.
        if ((r_state == S_DSET || r_state == S_DIV) && n_state == S_OUT) begin
            n_q = w_q_next;
            unique case (r_sel)
                SEL_LOST:  n_fl = w_q_next;
                SEL_DISC:  n_fd = w_q_next;
                SEL_BURST: n_bd = w_q_next;
                default:   n_bd = r_bd;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_fill      <= '0;
            r_recv      <= '0;
            r_disc      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_fill      <= n_fill;
            r_recv      <= n_recv;
            r_disc      <= n_disc;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_issue    <= n_issue;
        r_lost     <= n_lost;
        r_run      <= n_run;
        r_gap      <= n_gap;
        r_open     <= n_open;
        r_bursts   <= n_bursts;
        r_total    <= n_total;
        r_rem      <= n_rem;
        r_den_sh   <= n_den_sh;
        r_k        <= n_k;
        r_sel      <= n_sel;
        r_q        <= n_q;
        r_fl       <= n_fl;
        r_fd       <= n_fd;
        r_bd       <= n_bd;
        r_out_data <= n_out_data;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(SEQ_STORE_DEPTH))
        else $error("fill count beyond store depth");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside the output step");

    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> (r_lost <= r_issue) && (r_bursts <= r_issue))
        else $error("walk counters ahead of issued slots");

    a_div_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_k <= 4'd8)
        else $error("division step out of range");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_s_tready && !o_m_tvalid)
        else $error("traffic during the clearing pass");
`endif

endmodule

### dv/rtp_loss_burst_statistics_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtp_loss_burst_statistics_test
// Drives packet, discard and report beats into the loss statistics block and
// checks every report field against typed values or a behavioural copy of the
// seen-bitmap, the saturating counters, the burst walk and the rounded fractions.
// The gap minimum is changed between phases, and both stream sides stall at random.
// ----------------------------------------------------------------------------
module rtp_loss_burst_statistics_test;

    localparam int unsigned SLOTS           = 65536;
    localparam logic [1:0]  OP_UNUSED       = 2'd3;
    localparam logic [2:0]  GAP_MIN_ADDR    = {rlbs_pkg::REG_GAP_MIN, 2'b00};
    localparam int unsigned PHASES          = 6;
    localparam int unsigned PHASE_ITEMS     = 214;
    localparam int unsigned SETTLE_CYCLES   = 64;
    localparam int unsigned PRESSURE_CYCLES = 3000;
    localparam int unsigned CYCLE_LIMIT     = 2000000;
    localparam logic [7:0]  GAP_PLAN [PHASES] = '{8'd1, 8'd255, 8'd0, 8'd4, 8'd16, 8'd16};

    // Bit layout of one result beat, most significant field first.
    typedef struct packed {
        logic [2:0]                  pad;
        logic [rlbs_pkg::FRAC_W-1:0] burst_ratio;
        logic [rlbs_pkg::SLOT_W-1:0] burst_count;
        logic [rlbs_pkg::FRAC_W-1:0] frac_disc;
        logic [rlbs_pkg::FRAC_W-1:0] frac_lost;
        logic [rlbs_pkg::SLOT_W-1:0] lost_count;
        logic [rlbs_pkg::CNT_W-1:0]  disc_count;
        logic [rlbs_pkg::CNT_W-1:0]  recv_count;
    } t_report;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] seq;
        logic        typed;
        t_report     want;
    } t_stim_row;

    localparam t_report NO_REPORT = '0;

    // Typed reports read: pad, ratio, burst, frac_disc, frac_lost, lost, disc, recv.
    localparam t_stim_row DIRECTED_ROWS [17] = '{
        {rlbs_pkg::OP_REPORT,  16'h0000, 1'b1,
         {3'd0, 9'd0, 17'd0, 9'd0, 9'd0, 17'd0, 32'd0, 32'd0}},
        {OP_UNUSED,            16'hFFFF, 1'b0, NO_REPORT},
        {rlbs_pkg::OP_REPORT,  16'hFFFF, 1'b1,
         {3'd0, 9'd0, 17'd0, 9'd0, 9'd0, 17'd0, 32'd0, 32'd0}},
        {rlbs_pkg::OP_DISCARD, 16'h5555, 1'b0, NO_REPORT},
        {rlbs_pkg::OP_REPORT,  16'h0000, 1'b1,
         {3'd0, 9'd0, 17'd0, 9'd256, 9'd0, 17'd0, 32'd1, 32'd0}},
        {rlbs_pkg::OP_RECV,    16'h0000, 1'b0, NO_REPORT},
        {rlbs_pkg::OP_REPORT,  16'h0000, 1'b1,
         {3'd0, 9'd0, 17'd0, 9'd128, 9'd0, 17'd0, 32'd1, 32'd1}},
        {rlbs_pkg::OP_RECV,    16'hFFFF, 1'b0, NO_REPORT},
        {rlbs_pkg::OP_RECV,    16'h0002, 1'b0, NO_REPORT},
        {rlbs_pkg::OP_REPORT,  16'hAAAA, 1'b1,
         {3'd0, 9'd0, 17'd0, 9'd51, 9'd51, 17'd1, 32'd1, 32'd3}},
        {rlbs_pkg::OP_RECV,    16'hAAAA, 1'b0, NO_REPORT},
        {rlbs_pkg::OP_RECV,    16'h5555, 1'b0, NO_REPORT},
        {OP_UNUSED,            16'h0000, 1'b0, NO_REPORT},
        {rlbs_pkg::OP_DISCARD, 16'hFFFF, 1'b0, NO_REPORT},
        {rlbs_pkg::OP_REPORT,  16'h0000, 1'b0, NO_REPORT},
        {rlbs_pkg::OP_RECV,    16'h0001, 1'b0, NO_REPORT},
        {rlbs_pkg::OP_REPORT,  16'h5555, 1'b0, NO_REPORT}
    };

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [2:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    wire  [31:0]  prdata;
    wire          pready;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [15:0]  s_tdata  = '0;   // [15:0] seq_no
    logic [1:0]   s_tuser  = '0;   // [1:0] op
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire  [127:0] m_tdata;         // fields as in t_report, recv_count lowest

    // Behavioural state of the block.
    bit          seen_slot [SLOTS];
    int unsigned fill_slots = 0;
    int unsigned recv_total = 0;
    int unsigned disc_total = 0;
    logic [7:0]  gap_limit  = rlbs_pkg::GAP_MIN_RESET;

    t_report     pending_reports [$];
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;
    int unsigned send_idle_pct   = 0;
    int unsigned recv_idle_pct   = 0;
    int unsigned hold_left       = 0;
    bit          pressure_req    = 1'b0;
    bit          pressure_served = 1'b0;

    rtp_loss_burst_statistics dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Rounded x*256/total with a half rounding up, held at 256.
    function automatic logic [rlbs_pkg::FRAC_W-1:0] frac_of(input longint unsigned x,
                                                            input longint unsigned total);
        longint unsigned q;
        if (total == 0)
            return '0;
        q = (x * 512 + total) / (2 * total);
        return (q > 256) ? 9'd256 : q[rlbs_pkg::FRAC_W-1:0];
    endfunction

    function automatic t_report tally_report();
        int unsigned     lost;
        int unsigned     bursts;
        int unsigned     run;
        int unsigned     gap;
        bit              in_burst;
        longint unsigned total;
        t_report         r;
        lost = 0;
        bursts = 0;
        run = 0;
        gap = 0;
        in_burst = 1'b0;
        for (int unsigned i = 0; i < fill_slots && i < SLOTS; i++) begin
            if (!seen_slot[i])
                lost++;
            if (in_burst) begin
                if (seen_slot[i])
                    gap++;
                else
                    gap = 0;
                if (gap >= gap_limit) begin
                    bursts += run - gap_limit;
                    in_burst = 1'b0;
                    run = 0;
                    gap = 0;
                end else begin
                    run++;
                end
            end else if (!seen_slot[i]) begin
                in_burst = 1'b1;
                run++;
            end
        end
        // A burst still open at the end counts only beyond the gap minimum.
        if (run > gap_limit)
            bursts += run - gap_limit;
        total = longint'(recv_total) + longint'(disc_total) + longint'(lost);
        r = '0;
        r.recv_count  = recv_total;
        r.disc_count  = disc_total;
        r.lost_count  = lost[rlbs_pkg::SLOT_W-1:0];
        r.frac_lost   = frac_of(lost, total);
        r.frac_disc   = frac_of(disc_total, total);
        r.burst_count = bursts[rlbs_pkg::SLOT_W-1:0];
        r.burst_ratio = frac_of(bursts, total);
        return r;
    endfunction

    function automatic bit apply_item(input logic [1:0] op, input logic [15:0] seq,
                                      output t_report r);
        r = '0;
        case (op)
            rlbs_pkg::OP_RECV: begin
                if (recv_total != 32'hFFFF_FFFF)
                    recv_total++;
                seen_slot[seq % SLOTS] = 1'b1;
                if (fill_slots < SLOTS)
                    fill_slots++;
                return 1'b0;
            end
            rlbs_pkg::OP_DISCARD: begin
                if (disc_total != 32'hFFFF_FFFF)
                    disc_total++;
                return 1'b0;
            end
            rlbs_pkg::OP_REPORT: begin
                r = tally_report();
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [15:0] seq,
                             input bit typed, input t_report typed_want);
        t_report want;
        bit      has_result;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= seq;
        s_tuser  <= op;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        has_result = apply_item(op, seq, want);
        if (has_result)
            pending_reports.push_back(typed ? typed_want : want);
    endtask

    task automatic apb_access(input bit wr, input logic [7:0] value,
                              output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= GAP_MIN_ADDR;
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_gap_min(input logic [7:0] want);
        logic [31:0] rd;
        apb_access(1'b0, 8'd0, rd);
        if (rd[7:0] !== want) begin
            $display("%0t: gap_min read expected %0d actual %0d", $time, want, rd[7:0]);
            error_count++;
        end
    endtask

    task automatic set_gap_min(input logic [7:0] value);
        logic [31:0] rd;
        apb_access(1'b1, value, rd);
        gap_limit = value;
        @(posedge i_clk);
        check_gap_min(value);
    endtask

    // Stops sending and waits until every expected report has arrived, then settles.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (pressure_req && !pressure_served) begin
            hold_left = PRESSURE_CYCLES;
            pressure_served = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_report got;
        t_report want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_reports.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("received_count", want.recv_count, got.recv_count);
                check_field("discarded_count", want.disc_count, got.disc_count);
                check_field("lost_count", want.lost_count, got.lost_count);
                check_field("fraction_lost", want.frac_lost, got.frac_lost);
                check_field("fraction_discarded", want.frac_disc, got.frac_disc);
                check_field("burst_count", want.burst_count, got.burst_count);
                check_field("burst_ratio", want.burst_ratio, got.burst_ratio);
                check_field("padding", want.pad, got.pad);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0]  gm;
        logic [1:0]  op;
        logic [15:0] seq;
        logic [15:0] cursor;
        int unsigned run_left;
        int unsigned pick;
        cursor = '0;
        run_left = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 84;
        check_gap_min(rlbs_pkg::GAP_MIN_RESET);
        foreach (DIRECTED_ROWS[k])
            send_item(DIRECTED_ROWS[k].op, DIRECTED_ROWS[k].seq,
                      DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);

        for (int unsigned p = 0; p < PHASES; p++) begin
            drain();
            gm = (p == 4) ? 8'($urandom_range(2, 40)) : GAP_PLAN[p];
            set_gap_min(gm);
            if (p < 2) begin
                send_idle_pct = 28;
                recv_idle_pct = 84;
            end else if (p < 4) begin
                send_idle_pct = 84;
                recv_idle_pct = 28;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 4 && n == 20)
                    pressure_req = 1'b1;
                pick = $urandom_range(0, 99);
                seq = 16'($urandom);
                if (pick < 70) begin
                    // Runs of consecutive sequence numbers broken by holes, with
                    // run lengths either side of the gap minimum.
                    op = rlbs_pkg::OP_RECV;
                    if (run_left == 0) begin
                        if ($urandom_range(0, 3) == 0)
                            cursor += 16'($urandom_range(1, gm + 8));
                        else
                            cursor += 16'($urandom_range(1, 4));
                        run_left = $urandom_range(1, 2 * gm + 2);
                    end
                    if ($urandom_range(0, 9) == 0) begin
                        seq = cursor - 16'($urandom_range(1, 8));
                    end else begin
                        seq = cursor;
                        cursor++;
                        run_left--;
                    end
                end else if (pick < 78) begin
                    op = rlbs_pkg::OP_RECV;
                end else if (pick < 88) begin
                    op = rlbs_pkg::OP_DISCARD;
                end else if (pick < 97) begin
                    op = rlbs_pkg::OP_REPORT;
                end else begin
                    op = OP_UNUSED;
                end
                send_item(op, seq, 1'b0, NO_REPORT);
            end
        end

        drain();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
